[rtl/ati_pkg.sv]
// ----------------------------------------------------------------------------
// ADC table interpolator package
// Widths, codes and sizes shared by the channel interfaces and the top level.
// ----------------------------------------------------------------------------
package ati_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SZ_W        = $clog2(TABLE_DEPTH + 1);
   localparam int PTR_W       = SZ_W + 1;

   // Field widths.
   localparam int REQ_TYPE_W  = 1;
   localparam int ENTRY_IDX_W = 4;
   localparam int KEY_W       = 17;
   localparam int VAL_W       = 16;
   localparam int SAMPLE_W    = 16;
   localparam int OFFSET_W    = 16;
   localparam int TSIZE_W     = 5;

   // Configuration port.
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE = 1'b1;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE   = 1'b0;
   localparam logic [REQ_TYPE_W-1:0] REQ_CONVERT = 1'b1;

   // Datapath widths of the interpolation.
   localparam int LKEY_W = SAMPLE_W + 2;
   localparam int DEN_W  = KEY_W + 1;
   localparam int DV_W   = VAL_W + 1;
   localparam int DK_W   = LKEY_W + 1;
   localparam int NUM_W  = DV_W + DK_W;
   localparam int SUM_W  = NUM_W + 2;
   localparam int CNT_W  = $clog2(NUM_W);

   localparam logic signed [SUM_W-1:0] VAL_MAX = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] VAL_MIN = -SUM_W'(32768);

endpackage

[rtl/ati_if.sv]
// ----------------------------------------------------------------------------
// ADC table interpolator channels
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface ati_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [ati_pkg::REQ_TYPE_W-1:0]         req_type;
   logic [ati_pkg::ENTRY_IDX_W-1:0]        entry_index;
   logic signed [ati_pkg::KEY_W-1:0]       entry_key;
   logic signed [ati_pkg::VAL_W-1:0]       entry_value;
   logic [ati_pkg::SAMPLE_W-1:0]           sample;

   modport source (output valid, req_type, entry_index, entry_key, entry_value, sample,
                   input ready);
   modport sink   (input valid, req_type, entry_index, entry_key, entry_value, sample,
                   output ready);
endinterface

interface ati_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ati_pkg::VAL_W-1:0]       value;
   logic                                   ok;

   modport source (output valid, value, ok, input ready);
   modport sink   (input valid, value, ok, output ready);
endinterface

[rtl/adc_table_interpolator_top.sv]
// ----------------------------------------------------------------------------
// ADC table interpolator
// A write goes straight to the response stage. A conversion on an empty table fails;
// otherwise it clamps at an end of the table, ends on an exact hit of a binary search
// of at most log2(depth) + 1 steps, or interpolates through a bit-serial divide.
// Throughput: one item at a time; a request is taken only when idle, and a full
// response register holds the sequencer until rsp ready. Reset clears the
// sequencer, the response valid and both registers; table contents are undefined.
// ----------------------------------------------------------------------------
module adc_table_interpolator_top (
   input  logic                                clock,
   input  logic                                reset,
   ati_req_if.sink                             req_ch,
   ati_rsp_if.source                           rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [ati_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ati_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_FIRST, S_LAST, S_BS_ISSUE, S_BS_CMP, S_RD_LO, S_RD_HI,
      S_DIFF, S_MUL, S_PREP, S_DIV, S_FIX, S_DONE
   } state_type;

   state_type                                  state_ff;

   // Configuration registers.
   logic [ati_pkg::OFFSET_W-1:0]               csr_offset_ff;
   logic [ati_pkg::TSIZE_W-1:0]                csr_table_size_ff;

   // Table memory and its registered read port.
   logic signed [ati_pkg::KEY_W-1:0]           key_mem [ati_pkg::TABLE_DEPTH];
   logic signed [ati_pkg::VAL_W-1:0]           val_mem [ati_pkg::TABLE_DEPTH];
   logic signed [ati_pkg::KEY_W-1:0]           rd_key_ff;
   logic signed [ati_pkg::VAL_W-1:0]           rd_val_ff;
   logic [ati_pkg::IDX_W-1:0]                  rd_addr;
   logic                                       mem_wr;

   // Search state.
   logic signed [ati_pkg::LKEY_W-1:0]          key_ff;
   logic signed [ati_pkg::LKEY_W-1:0]          key_in;
   logic [ati_pkg::SZ_W-1:0]                   size_ff;
   logic [ati_pkg::SZ_W-1:0]                   size_in;
   logic signed [ati_pkg::PTR_W-1:0]           lo_ff;
   logic signed [ati_pkg::PTR_W-1:0]           hi_ff;
   logic signed [ati_pkg::PTR_W-1:0]           last_ptr;
   logic signed [ati_pkg::PTR_W-1:0]           mid_ptr;
   logic signed [ati_pkg::PTR_W:0]             mid_sum;
   logic [ati_pkg::IDX_W-1:0]                  mid_ff;
   logic [ati_pkg::IDX_W-1:0]                  mid_in;
   logic signed [ati_pkg::LKEY_W-1:0]          rd_key_ext;

   // Interpolation datapath.
   logic signed [ati_pkg::KEY_W-1:0]           klo_ff;
   logic signed [ati_pkg::VAL_W-1:0]           vlo_ff;
   logic signed [ati_pkg::VAL_W-1:0]           vhi_ff;
   logic signed [ati_pkg::DEN_W-1:0]           den_ff;
   logic signed [ati_pkg::DEN_W-1:0]           den_in;
   logic signed [ati_pkg::DV_W-1:0]            dv_ff;
   logic signed [ati_pkg::DK_W-1:0]            dk_ff;
   logic signed [ati_pkg::NUM_W-1:0]           num_ff;
   logic signed [ati_pkg::NUM_W-1:0]           num_in;
   logic [ati_pkg::NUM_W-1:0]                  dvd_ff;
   logic [ati_pkg::DEN_W-1:0]                  dmag_ff;
   logic [ati_pkg::DEN_W-1:0]                  rem_ff;
   logic [ati_pkg::DEN_W:0]                    rem_sh;
   logic [ati_pkg::DEN_W:0]                    trial;
   logic                                       neg_ff;
   logic [ati_pkg::CNT_W-1:0]                  cnt_ff;
   logic signed [ati_pkg::SUM_W-1:0]           quot_ext;
   logic signed [ati_pkg::SUM_W-1:0]           sum_in;

   // Result and response registers.
   logic signed [ati_pkg::VAL_W-1:0]           res_value_ff;
   logic                                       res_ok_ff;
   logic signed [ati_pkg::VAL_W-1:0]           rsp_value_ff;
   logic                                       rsp_ok_ff;
   logic                                       rsp_valid_ff;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.value = rsp_value_ff;
   assign rsp_ch.ok    = rsp_ok_ff;

   // ------------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_offset_ff     <= '0;
         csr_table_size_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ati_pkg::CSR_OFFSET: begin
               csr_offset_ff <= csr_wr_data[ati_pkg::OFFSET_W-1:0];
            end
            ati_pkg::CSR_TABLE_SIZE: begin
               csr_table_size_ff <= csr_wr_data[ati_pkg::TSIZE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Table memory: one write port on a write transfer, one registered read.
   // ------------------------------------------------------------------------
   assign mem_wr = req_ch.valid && req_ch.ready && (req_ch.req_type == ati_pkg::REQ_WRITE) &&
                   (32'(req_ch.entry_index) < ati_pkg::TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         key_mem[ati_pkg::IDX_W'(req_ch.entry_index)] <= req_ch.entry_key;
         val_mem[ati_pkg::IDX_W'(req_ch.entry_index)] <= req_ch.entry_value;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
   end

   // ------------------------------------------------------------------------
   // Sequencer support logic.
   // ------------------------------------------------------------------------
   always_comb begin
      if (int'(csr_table_size_ff) > ati_pkg::TABLE_DEPTH) begin
         size_in = ati_pkg::SZ_W'(ati_pkg::TABLE_DEPTH);
      end else begin
         size_in = ati_pkg::SZ_W'(csr_table_size_ff);
      end
      if (csr_offset_ff != '0) begin
         key_in = $signed({2'b00, csr_offset_ff}) - $signed({2'b00, req_ch.sample});
      end else begin
         key_in = $signed({2'b00, req_ch.sample});
      end
   end

   assign last_ptr   = $signed({1'b0, size_ff}) - ati_pkg::PTR_W'(1);
   assign mid_sum    = (ati_pkg::PTR_W + 1)'(lo_ff) + (ati_pkg::PTR_W + 1)'(hi_ff);
   assign mid_in     = mid_sum[ati_pkg::IDX_W:1];
   assign mid_ptr    = $signed({{(ati_pkg::PTR_W - ati_pkg::IDX_W){1'b0}}, mid_ff});
   assign rd_key_ext = ati_pkg::LKEY_W'(rd_key_ff);

   // The address is chosen in the state before the one that uses the registered data.
   always_comb begin
      case (state_ff)
         S_FIRST:    rd_addr = ati_pkg::IDX_W'(size_ff - 1'b1);
         S_BS_ISSUE: rd_addr = mid_in;
         S_RD_LO:    rd_addr = lo_ff[ati_pkg::IDX_W-1:0];
         S_RD_HI:    rd_addr = hi_ff[ati_pkg::IDX_W-1:0];
         default:    rd_addr = '0;
      endcase
   end

   assign den_in = ati_pkg::DEN_W'(klo_ff) - ati_pkg::DEN_W'(rd_key_ff);
   assign num_in = dv_ff * dk_ff;

   // One restoring divide step per cycle.
   assign rem_sh = {rem_ff, dvd_ff[ati_pkg::NUM_W-1]};
   assign trial  = rem_sh - {1'b0, dmag_ff};

   assign quot_ext = $signed({2'b00, dvd_ff});
   assign sum_in   = ati_pkg::SUM_W'(vhi_ff) + (neg_ff ? -quot_ext : quot_ext);

   // ------------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In S_DONE the response register is reloaded below instead.
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  res_value_ff <= '0;
                  if (req_ch.req_type == ati_pkg::REQ_CONVERT) begin
                     if (size_in == '0) begin
                        res_ok_ff <= 1'b0;
                        state_ff  <= S_DONE;
                     end else begin
                        res_ok_ff <= 1'b1;
                        key_ff    <= key_in;
                        size_ff   <= size_in;
                        state_ff  <= S_FIRST;
                     end
                  end else begin
                     res_ok_ff <= 1'b1;
                     state_ff  <= S_DONE;
                  end
               end
            end
            S_FIRST: begin
               if (rd_key_ext >= key_ff) begin
                  res_value_ff <= rd_val_ff;
                  state_ff     <= S_DONE;
               end else begin
                  state_ff <= S_LAST;
               end
            end
            S_LAST: begin
               if (rd_key_ext <= key_ff) begin
                  res_value_ff <= rd_val_ff;
                  state_ff     <= S_DONE;
               end else begin
                  lo_ff    <= '0;
                  hi_ff    <= last_ptr;
                  state_ff <= S_BS_ISSUE;
               end
            end
            S_BS_ISSUE: begin
               if (lo_ff <= hi_ff) begin
                  mid_ff   <= mid_in;
                  state_ff <= S_BS_CMP;
               end else begin
                  // Out of the search: pull both neighbors back into the table.
                  if (hi_ff < 0) begin
                     hi_ff <= '0;
                  end
                  if (lo_ff > last_ptr) begin
                     lo_ff <= last_ptr;
                  end
                  state_ff <= S_RD_LO;
               end
            end
            S_BS_CMP: begin
               if (rd_key_ext > key_ff) begin
                  hi_ff    <= mid_ptr - ati_pkg::PTR_W'(1);
                  state_ff <= S_BS_ISSUE;
               end else if (rd_key_ext < key_ff) begin
                  lo_ff    <= mid_ptr + ati_pkg::PTR_W'(1);
                  state_ff <= S_BS_ISSUE;
               end else begin
                  res_value_ff <= rd_val_ff;
                  state_ff     <= S_DONE;
               end
            end
            S_RD_LO: begin
               state_ff <= S_RD_HI;
            end
            S_RD_HI: begin
               klo_ff   <= rd_key_ff;
               vlo_ff   <= rd_val_ff;
               state_ff <= S_DIFF;
            end
            S_DIFF: begin
               if (den_in == '0) begin
                  res_value_ff <= rd_val_ff;
                  state_ff     <= S_DONE;
               end else begin
                  den_ff   <= den_in;
                  dv_ff    <= ati_pkg::DV_W'(vlo_ff) - ati_pkg::DV_W'(rd_val_ff);
                  dk_ff    <= ati_pkg::DK_W'(key_ff) - ati_pkg::DK_W'(rd_key_ff);
                  vhi_ff   <= rd_val_ff;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               num_ff   <= num_in;
               state_ff <= S_PREP;
            end
            S_PREP: begin
               dvd_ff   <= num_ff[ati_pkg::NUM_W-1] ? $unsigned(-num_ff) : $unsigned(num_ff);
               dmag_ff  <= den_ff[ati_pkg::DEN_W-1] ? $unsigned(-den_ff) : $unsigned(den_ff);
               neg_ff   <= num_ff[ati_pkg::NUM_W-1] ^ den_ff[ati_pkg::DEN_W-1];
               rem_ff   <= '0;
               cnt_ff   <= ati_pkg::CNT_W'(ati_pkg::NUM_W - 1);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (!trial[ati_pkg::DEN_W]) begin
                  rem_ff <= trial[ati_pkg::DEN_W-1:0];
                  dvd_ff <= {dvd_ff[ati_pkg::NUM_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[ati_pkg::DEN_W-1:0];
                  dvd_ff <= {dvd_ff[ati_pkg::NUM_W-2:0], 1'b0};
               end
               if (cnt_ff == '0) begin
                  state_ff <= S_FIX;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            S_FIX: begin
               if (sum_in > ati_pkg::VAL_MAX) begin
                  res_value_ff <= ati_pkg::VAL_W'(ati_pkg::VAL_MAX);
               end else if (sum_in < ati_pkg::VAL_MIN) begin
                  res_value_ff <= ati_pkg::VAL_W'(ati_pkg::VAL_MIN);
               end else begin
                  res_value_ff <= ati_pkg::VAL_W'(sum_in);
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               // Hand the result to the response register once it is free.
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_value_ff <= res_value_ff;
                  rsp_ok_ff    <= res_ok_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff != S_IDLE))
      else $error("transfer accepted but sequencer stayed idle");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid_ff || rsp_ch.ready)) |=>
      (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished result not moved to the response register");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (dmag_ff != '0))
      else $error("divider running with a zero divisor");

   a_mid_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BS_ISSUE && lo_ff <= hi_ff) |-> (ati_pkg::SZ_W'(mid_in) < size_ff))
      else $error("search probe outside the table in use");

endmodule

[sim/ati_result_monitor.sv]
// ----------------------------------------------------------------------------
// ADC table interpolator result monitor
// Watches the request, response and register ports of the interpolator,
// keeps its own copy of the lookup table and registers, works out the
// response each accepted request should produce and compares every
// response transfer against the oldest one still awaited.
// ----------------------------------------------------------------------------
module ati_result_monitor (
   input  logic                                clock,
   input  logic                                reset,
   ati_req_if                                  req_mon,
   ati_rsp_if                                  rsp_mon,
   input  logic                                csr_wr_en,
   input  logic [ati_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ati_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   output int                                  mismatch_count,
   output int                                  results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic signed [ati_pkg::VAL_W-1:0] value;
      logic                             ok;
   } result_type;

   logic [ati_pkg::OFFSET_W-1:0]     offset_reg;
   logic [ati_pkg::TSIZE_W-1:0]      size_reg;
   logic signed [ati_pkg::KEY_W-1:0] key_shadow   [ati_pkg::TABLE_DEPTH];
   logic signed [ati_pkg::VAL_W-1:0] value_shadow [ati_pkg::TABLE_DEPTH];
   result_type                       awaited_results [$];

   // Converts one reading through the shadow table: clamp at both ends,
   // exact hit, or a linear step between the neighbours the search ends on.
   function automatic result_type interpolate_reading(
      input logic [ati_pkg::SAMPLE_W-1:0] smp);
      result_type r;
      int         n, lo, hi, mid;
      bit         hit;
      longint     lookup, num, den, acc;
      r.ok    = 1'b1;
      r.value = '0;
      hit     = 1'b0;
      n = (size_reg > ati_pkg::TABLE_DEPTH) ? ati_pkg::TABLE_DEPTH : int'(size_reg);
      if (n == 0) begin
         r.ok = 1'b0;
         return r;
      end
      lookup = (offset_reg != 0) ? longint'(offset_reg) - longint'(smp) : longint'(smp);
      if (longint'(key_shadow[0]) >= lookup) begin
         r.value = value_shadow[0];
         return r;
      end
      if (longint'(key_shadow[n-1]) <= lookup) begin
         r.value = value_shadow[n-1];
         return r;
      end
      lo = 0;
      hi = n - 1;
      while (lo <= hi && !hit) begin
         mid = (lo + hi) / 2;
         if (longint'(key_shadow[mid]) > lookup) hi = mid - 1;
         else if (longint'(key_shadow[mid]) < lookup) lo = mid + 1;
         else begin
            hit     = 1'b1;
            r.value = value_shadow[mid];
         end
      end
      if (hit) return r;
      if (hi < 0) hi = 0;
      if (lo > n - 1) lo = n - 1;
      den = longint'(key_shadow[lo]) - longint'(key_shadow[hi]);
      if (den == 0) begin
         r.value = value_shadow[hi];
         return r;
      end
      num = (longint'(value_shadow[lo]) - longint'(value_shadow[hi])) *
            (lookup - longint'(key_shadow[hi]));
      // SystemVerilog division truncates toward zero, as the block must.
      acc = longint'(value_shadow[hi]) + num / den;
      if (acc > 32767) acc = 32767;
      else if (acc < -32768) acc = -32768;
      r.value = ati_pkg::VAL_W'(acc);
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want, got;
      if (reset) begin
         offset_reg     = '0;
         size_reg       = '0;
         mismatch_count = 0;
         awaited_results.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == ati_pkg::CSR_OFFSET)
               offset_reg = csr_wr_data[ati_pkg::OFFSET_W-1:0];
            else if (csr_index == ati_pkg::CSR_TABLE_SIZE)
               size_reg = csr_wr_data[ati_pkg::TSIZE_W-1:0];
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.req_type == ati_pkg::REQ_WRITE) begin
               key_shadow[req_mon.entry_index]   = req_mon.entry_key;
               value_shadow[req_mon.entry_index] = req_mon.entry_value;
               want.value = '0;
               want.ok    = 1'b1;
            end else begin
               want = interpolate_reading(req_mon.sample);
            end
            awaited_results.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.value = rsp_mon.value;
            got.ok    = rsp_mon.ok;
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: response transfer with none awaited: value=%0d ok=%0b",
                           $realtime, got.value, got.ok);
            end else begin
               want = awaited_results.pop_front();
               if (got.value !== want.value || got.ok !== want.ok) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: response mismatch: expected value=%0d ok=%0b, got value=%0d ok=%0b",
                              $realtime, want.value, want.ok, got.value, got.ok);
               end
            end
         end
      end
      results_pending = awaited_results.size();
   end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// ADC table interpolator testbench
// Resets the block, loads lookup tables and registers, and sends directed
// then random table writes and conversions under varying back-pressure on
// both channels. A result monitor predicts and checks every response; this
// module drives stimulus, guards against a hang and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 10;
   localparam int RANDOM_ITEMS   = 450;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 100;
   localparam int WATCHDOG_LIMIT = 3000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en   = 1'b0;
   logic [ati_pkg::CSR_IDX_W-1:0]  csr_index   = ati_pkg::CSR_OFFSET;
   logic [ati_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;
   int                             mismatches;
   int                             results_pending;

   int sender_idle   [3] = '{27, 78, 0};
   int receiver_idle [3] = '{78, 27, 0};
   int req_idle_pct;
   int rsp_idle_pct;
   bit hold_armed;
   int items_sent;
   int cur_offset;
   int table_keys [ati_pkg::TABLE_DEPTH];

   ati_req_if req_if();
   ati_rsp_if rsp_if();

   adc_table_interpolator_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   ati_result_monitor result_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatches),
      .results_pending (results_pending)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Response ready: random stalls, plus one long hold-off once it is armed.
   initial begin
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   // Starts and ends at a falling edge; the transfer happens at a rising edge.
   task automatic offer(input logic [ati_pkg::REQ_TYPE_W-1:0] kind, input int idx,
                        input int key, input int val, input int smp);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.req_type    <= kind;
      req_if.entry_index <= ati_pkg::ENTRY_IDX_W'(idx);
      req_if.entry_key   <= ati_pkg::KEY_W'(key);
      req_if.entry_value <= ati_pkg::VAL_W'(val);
      req_if.sample      <= ati_pkg::SAMPLE_W'(smp);
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic store_entry(input int idx, input int key, input int val);
      table_keys[idx] = key;
      offer(ati_pkg::REQ_WRITE, idx, key, val, $urandom_range(16'hFFFF));
   endtask

   task automatic convert_reading(input int smp);
      offer(ati_pkg::REQ_CONVERT, $urandom_range(ati_pkg::TABLE_DEPTH - 1),
            $urandom_range(17'h1FFFF), $urandom_range(16'hFFFF), smp);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_registers(input int off, input int size);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_index   <= ati_pkg::CSR_OFFSET;
      csr_wr_data <= ati_pkg::CSR_DATA_W'(off);
      @(negedge clock);
      csr_index   <= ati_pkg::CSR_TABLE_SIZE;
      csr_wr_data <= ati_pkg::CSR_DATA_W'(size);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_offset = off;
   endtask

   function automatic int lookup_key(input int smp);
      return (cur_offset != 0) ? cur_offset - smp : smp;
   endfunction

   // Readings aimed at the ends of the range and at exact table keys, or drawn at random.
   function automatic int pick_sample();
      int s;
      case ($urandom_range(9))
         0:       s = 0;
         1:       s = 65535;
         2, 3:    s = lookup_key(table_keys[$urandom_range(ati_pkg::TABLE_DEPTH - 1)]);
         default: s = $urandom_range(65535);
      endcase
      if (s < 0 || s > 65535) s = $urandom_range(65535);
      return s;
   endfunction

   // Fills the whole table with keys clustered around the reachable lookup
   // keys; a narrow spread gives repeated keys, and some tables stay unsorted.
   task automatic load_table();
      int keys [$];
      int span, base, k;
      bit ordered;
      case ($urandom_range(3))
         0:       span = 30;
         1:       span = 2000;
         2:       span = 65535;
         default: span = 131071;
      endcase
      ordered = ($urandom_range(4) != 0);
      base = lookup_key($urandom_range(65535)) - span / 2;
      for (int i = 0; i < ati_pkg::TABLE_DEPTH; i++) begin
         k = base + int'($urandom_range(span));
         if (k < -65536) k = -65536;
         if (k > 65535) k = 65535;
         keys.push_back(k);
      end
      if (ordered) keys.sort();
      for (int i = 0; i < ati_pkg::TABLE_DEPTH; i++)
         store_entry(i, keys[i], int'($urandom_range(65535)) - 32768);
   endtask

   task automatic run_segment(input int n_items);
      int off, size;
      case ($urandom_range(5))
         0, 1:    off = 0;
         2:       off = 65535;
         3:       off = 1;
         default: off = $urandom_range(1, 65535);
      endcase
      case ($urandom_range(7))
         0:       size = 0;
         1:       size = 1;
         2:       size = ati_pkg::TABLE_DEPTH;
         3:       size = $urandom_range(ati_pkg::TABLE_DEPTH + 1, 31);
         default: size = $urandom_range(2, ati_pkg::TABLE_DEPTH - 1);
      endcase
      set_registers(off, size);
      if ($urandom_range(3) != 0) load_table();
      repeat (n_items) begin
         if ($urandom_range(6) == 0)
            store_entry($urandom_range(ati_pkg::TABLE_DEPTH - 1),
                        int'($urandom_range(131071)) - 65536,
                        int'($urandom_range(65535)) - 32768);
         else
            convert_reading(pick_sample());
      end
   endtask

   initial begin
      int random_base;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_armed   = 1'b0;
      items_sent   = 0;
      cur_offset   = 0;
      req_if.valid       = 1'b0;
      req_if.req_type    = ati_pkg::REQ_WRITE;
      req_if.entry_index = '0;
      req_if.entry_key   = '0;
      req_if.entry_value = '0;
      req_if.sample      = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty table: conversions fail before anything is loaded.
      set_registers(0, 0);
      convert_reading(0);
      convert_reading(65535);

      // Ascending table spanning the full key range, values swinging rail to rail.
      for (int i = 0; i < ati_pkg::TABLE_DEPTH; i++)
         store_entry(i, (i == ati_pkg::TABLE_DEPTH - 1) ? 65535 : -65536 + i * 8737,
                     (i % 2) ? -32768 : 32767);
      set_registers(0, ati_pkg::TABLE_DEPTH);
      convert_reading(0);
      convert_reading(4360);
      convert_reading(65535);

      // Largest offset with an oversized table size, which saturates to the depth.
      set_registers(65535, 31);
      convert_reading(0);
      convert_reading(65535);

      // A single entry clamps every reading to its value.
      set_registers(1, 1);
      convert_reading(0);
      convert_reading(65535);

      // Entry 0 now sits above entry 1, so the table is no longer ascending.
      set_registers(0, ati_pkg::TABLE_DEPTH);
      store_entry(0, 100, 5);
      convert_reading(50);
      convert_reading(200);

      random_base = items_sent;
      for (int ph = 0; ph < 3; ph++) begin
         req_idle_pct = sender_idle[ph];
         rsp_idle_pct = receiver_idle[ph];
         if (ph == 0) begin
            run_segment($urandom_range(20, 40));
            // The receiver holds off while requests keep coming.
            hold_armed = 1'b1;
            repeat (20) convert_reading(pick_sample());
         end
         while (items_sent < random_base + (ph + 1) * RANDOM_ITEMS / 3)
            run_segment($urandom_range(20, 40));
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[sim.f]
rtl/ati_pkg.sv
rtl/ati_if.sv
rtl/adc_table_interpolator_top.sv
sim/ati_result_monitor.sv
sim/testbench.sv
